@@ rtl/sha_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 hasher.
`default_nettype none
package sha_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam logic [7:0] PadByte    = 8'h80;
  localparam logic [5:0] LenBytePos = 6'd56;

  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } sha_req_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = 32'h0;
    endcase
    init_word = v;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] v;
    unique case (idx)
      6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491; 6'd2:  v = 32'hb5c0fbcf;
      6'd3:  v = 32'he9b5dba5; 6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5; 6'd8:  v = 32'hd807aa98;
      6'd9:  v = 32'h12835b01; 6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe; 6'd14: v = 32'h9bdc06a7;
      6'd15: v = 32'hc19bf174; 6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc; 6'd20: v = 32'h2de92c6f;
      6'd21: v = 32'h4a7484aa; 6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d; 6'd26: v = 32'hb00327c8;
      6'd27: v = 32'hbf597fc7; 6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967; 6'd32: v = 32'h27b70a85;
      6'd33: v = 32'h2e1b2138; 6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb; 6'd38: v = 32'h81c2c92e;
      6'd39: v = 32'h92722c85; 6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3; 6'd44: v = 32'hd192e819;
      6'd45: v = 32'hd6990624; 6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08; 6'd50: v = 32'h2748774c;
      6'd51: v = 32'h34b0bcb5; 6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3; 6'd56: v = 32'h748f82ee;
      6'd57: v = 32'h78a5636f; 6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb; 6'd62: v = 32'hbef9a3f7;
      6'd63: v = 32'hc67178f2;
      default: v = 32'h0;
    endcase
    round_const = v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sha_front.sv @@
// Input side: accepts requests, classifies them and queues them for the core.
`default_nettype none
module sha_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [7:0] data_byte
  input  wire logic             s_tuser,   // [0] command
  output sha_pkg::sha_req_t     req,
  output logic                  req_valid,
  input  wire logic             req_ready
);
  import sha_pkg::*;

  sha_req_t               queue [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueuePtrW:0]     count;
  logic                   push;
  logic                   pop;
  sha_req_t               req_in;

  assign s_tready  = (count != (QueuePtrW + 1)'(QueueDepth));
  assign req_valid = (count != '0);
  assign push      = s_tvalid & s_tready;
  assign pop       = req_valid & req_ready;
  assign req       = queue[rd_ptr];

  always_comb begin
    req_in.finish = s_tuser;
    req_in.data   = s_tuser ? 8'h00 : s_tdata;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= req_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/sha_core.sv @@
// Block buffer, padding, 64-round compression and digest output register.
`default_nettype none
module sha_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sha_pkg::sha_req_t req,
  input  wire logic             req_valid,
  output logic                  req_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           out_word,
  output logic [2:0]            out_idx,
  output logic                  out_last
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_EMIT  = 4'b1000
  } core_state_t;

  core_state_t  state;
  logic [31:0]  win [16];
  logic [31:0]  ws [8];
  logic [31:0]  h [8];
  logic [5:0]   fill;
  logic [60:0]  count;
  logic [5:0]   round_idx;
  logic         final_blk;
  logic         len_pend;
  logic [63:0]  length;
  logic [2:0]   emit_idx;

  logic [63:0]  bits;
  logic [31:0]  pad_word [16];
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  ch;
  logic [31:0]  maj;
  logic [31:0]  w_new;
  logic [31:0]  h_sum [8];
  logic         out_load;
  logic [7:0]   byte_v;

  assign req_ready = (state == ST_IDLE);
  assign bits      = {count, 3'b000};
  assign out_load  = (state == ST_EMIT) && (!out_valid || out_ready);

  // padded buffer: 0x80 at fill point, zeros after, length if it fits
  always_comb begin
    byte_v = 8'h00;
    for (int w = 0; w < 16; w++) begin
      for (int b = 0; b < 4; b++) begin
        if (6'(w * 4 + b) == fill) byte_v = PadByte;
        else if (6'(w * 4 + b) > fill) byte_v = 8'h00;
        else byte_v = win[w][8 * (3 - b) +: 8];
        pad_word[w][8 * (3 - b) +: 8] = byte_v;
      end
    end
    if (fill < LenBytePos) begin
      pad_word[14] = bits[63:32];
      pad_word[15] = bits[31:0];
    end
  end

  always_comb begin
    ch    = (ws[4] & ws[5]) ^ (~ws[4] & ws[6]);
    maj   = (ws[0] & ws[1]) ^ (ws[0] & ws[2]) ^ (ws[1] & ws[2]);
    t1    = ws[7] + big_sig1(ws[4]) + ch + round_const(round_idx) + win[0];
    t2    = big_sig0(ws[0]) + maj;
    w_new = sml_sig1(win[14]) + win[9] + sml_sig0(win[1]) + win[0];
    for (int i = 0; i < 8; i++) begin
      h_sum[i] = h[i] + ws[i];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (!req.finish) begin
            win[fill[5:2]][(5'd24 - {fill[1:0], 3'b000}) +: 8] <= req.data;
            if (fill == 6'd63) ws <= h;
          end else begin
            win    <= pad_word;
            ws     <= h;
            length <= bits;
          end
        end
      end
      ST_ROUND: begin
        ws[7] <= ws[6];
        ws[6] <= ws[5];
        ws[5] <= ws[4];
        ws[4] <= ws[3] + t1;
        ws[3] <= ws[2];
        ws[2] <= ws[1];
        ws[1] <= ws[0];
        ws[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i + 1];
        end
        win[15] <= w_new;
      end
      ST_ADD: begin
        if (len_pend) begin
          for (int i = 0; i < 14; i++) begin
            win[i] <= 32'h0;
          end
          win[14] <= length[63:32];
          win[15] <= length[31:0];
          ws      <= h_sum;
        end
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_word <= h[0];
      out_idx  <= emit_idx;
      out_last <= (emit_idx == 3'd7);
    end
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      count     <= '0;
      round_idx <= '0;
      final_blk <= 1'b0;
      len_pend  <= 1'b0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= init_word(3'(i));
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            round_idx <= '0;
            if (!req.finish) begin
              fill  <= fill + 1'b1;
              count <= count + 1'b1;
              if (fill == 6'd63) begin
                final_blk <= 1'b0;
                len_pend  <= 1'b0;
                state     <= ST_ROUND;
              end
            end else begin
              fill      <= '0;
              count     <= '0;
              final_blk <= (fill < LenBytePos);
              len_pend  <= !(fill < LenBytePos);
              state     <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          round_idx <= round_idx + 1'b1;
          if (round_idx == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          h <= h_sum;
          if (len_pend) begin
            len_pend  <= 1'b0;
            final_blk <= 1'b1;
            round_idx <= '0;
            state     <= ST_ROUND;
          end else if (final_blk) begin
            emit_idx <= '0;
            state    <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            // rotate out the digest and refill with the initial values
            for (int i = 0; i < 7; i++) begin
              h[i] <= h[i + 1];
            end
            h[7]     <= init_word(emit_idx);
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 3'd7) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sha256_byte_stream_hasher.sv @@
// SHA-256 over a byte stream: top level joining request queue and hash core.
//
// Input channel (s_*): one request per handshake. s_tuser = 0 absorbs the
// byte in s_tdata[7:0]; s_tuser = 1 finishes the message (s_tdata ignored).
// A four-entry request queue sits in front of the core, so the source can
// keep sending while a block is compressed.
// Output channel (m_*): on finish, eight digest words, word 0 first; word
// index in m_tdata[34:32], m_tlast on word 7. Absorb gives no output.
// Compression: the 64th byte of a block starts 64 rounds, one round per
// clock, then an add step folds the result into the hash state. Finish
// pads and compresses the buffered block, plus a second block holding the
// length when 56 or more bytes were buffered, then emits the digest words.
// After finish the hash state is back to its initial values.
// Reset (rst, synchronous) empties the queue and restores the initial state.
// A stalled receiver holds the current word in the output register; the
// core waits in emission and the queue keeps accepting until full.
`default_nettype none
module sha256_byte_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic             m_tlast    // last_word
);
  import sha_pkg::*;

  sha_req_t     req;
  logic         req_valid;
  logic         req_ready;
  logic [31:0]  out_word;
  logic [2:0]   out_idx;

  sha_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready)
  );

  sha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word),
    .out_idx   (out_idx),
    .out_last  (m_tlast)
  );

  assign m_tdata = {5'b00000, out_idx, out_word};

endmodule
`default_nettype wire
